// File: design/sorted_priority_queue_top_macros.svh
// Assertion macros for the sorted priority queue top level.
`ifndef SORTED_PRIORITY_QUEUE_TOP_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_TOP_MACROS_SVH

`ifndef ASSERT_OFF
// Clocked check that is switched off while reset is high.
`define SPQ_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Clocked check that stays live during reset.
`define SPQ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SPQ_ASSERT(lbl, clk, rst, prop, msg)
`define SPQ_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// File: design/spq_pkg.sv
// Package with the types and constants of the sorted priority queue.
package spq_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int VAL_W     = 32;
  localparam int STAT_W    = 2;
  localparam int OCC_W     = 5;

  // Command codes carried by an input word.
  typedef enum logic {
    CMD_ENQUEUE = 1'b0,
    CMD_DEQUEUE = 1'b1
  } cmd_t;

  // Status codes carried by a result word.
  typedef enum logic [STAT_W-1:0] {
    ST_ENQUEUED  = 2'd0,
    ST_DEQUEUED  = 2'd1,
    ST_OVERFLOW  = 2'd2,
    ST_UNDERFLOW = 2'd3
  } status_t;

  // Operation broadcast to every cell of the row.
  typedef struct packed {
    logic                    enq;
    logic                    deq;
    logic signed [VAL_W-1:0] val;
  } cell_ctrl_t;

endpackage

// File: design/spq_if.sv
// Handshake interfaces for the command and result channels.
interface spq_cmd_if import spq_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    command;
  logic signed [VAL_W-1:0] value;

  modport source (output valid, command, value, input ready);
  modport sink   (input valid, command, value, output ready);
endinterface

interface spq_res_if import spq_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [STAT_W-1:0]       status;
  logic signed [VAL_W-1:0] removed_value;
  logic [OCC_W-1:0]        occupancy;

  modport source (output valid, status, removed_value, occupancy, input ready);
  modport sink   (input valid, status, removed_value, occupancy, output ready);
endinterface

// File: design/spq_cell.sv
// One compare-and-shift cell of the sorted storage row.
module spq_cell import spq_pkg::*; (
  input  logic                    clk,
  input  cell_ctrl_t              ctrl,
  input  logic                    occ,
  input  logic                    left_take,
  input  logic signed [VAL_W-1:0] left_value,
  input  logic signed [VAL_W-1:0] right_value,
  output logic                    take,
  output logic signed [VAL_W-1:0] value
);

  logic signed [VAL_W-1:0] value_next;

  // A free cell, or one holding a strictly greater value, moves up on enqueue.
  assign take = !occ || (value > ctrl.val);

  // Enqueue shifts from the left or loads the new word; dequeue shifts from the right.
  always_comb begin
    value_next = value;
    if (ctrl.enq) begin
      if (take) begin
        value_next = left_take ? left_value : ctrl.val;
      end
    end else if (ctrl.deq) begin
      value_next = right_value;
    end
  end

  always_ff @(posedge clk) begin
    value <= value_next;
  end

endmodule

// File: design/sorted_priority_queue_top.sv
// Sorted priority queue: the top level with its row of cells.
//
// The cmd channel takes one word per command: command selects enqueue or
// dequeue, value is the signed number to store on enqueue. The res channel
// returns exactly one word per command with a status, the removed value
// (zero unless a dequeue succeeded) and the occupancy after the command.
// Up to DEPTH values are held in ascending order in a row of cells; equal
// values leave in the order in which they arrived.
// An accepted command's result word is registered and offered in the next
// cycle. The row updates every cell in the same cycle with one compare and
// a shift to or from a neighbour, so a new command is taken every cycle
// unless a result is stalled. A result waits in an output register;
// cmd.ready stays high while that register is empty or is being read, so a
// stalled receiver holds off new commands only once a result is waiting.
// Reset empties the queue and drops any pending result at once; stored
// values themselves are not cleared and are never read before written.
// Enqueue into a full queue reports overflow, dequeue from an empty one
// reports underflow; neither changes the contents.
`include "sorted_priority_queue_top_macros.svh"

module sorted_priority_queue_top import spq_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input logic         clk,
  input logic         rst,
  spq_cmd_if.sink     cmd,
  spq_res_if.source   res
);

  localparam int CW = $clog2(DEPTH + 1);

  logic [CW-1:0]           count;
  logic [CW-1:0]           count_next;
  logic                    full;
  logic                    empty;
  logic                    accept;
  logic                    is_deq;
  cell_ctrl_t              ctrl;
  logic                    take   [DEPTH];
  logic signed [VAL_W-1:0] value  [DEPTH];
  logic                    res_valid;
  status_t                 res_status;
  status_t                 status_next;
  logic signed [VAL_W-1:0] res_removed;
  logic [OCC_W-1:0]        res_occ;

  // Handshake: a new word is taken whenever the result register is free.
  assign cmd.ready = !res_valid || res.ready;
  assign accept    = cmd.valid && cmd.ready;
  assign is_deq    = (cmd.command == CMD_DEQUEUE);
  assign full      = (count == CW'(DEPTH));
  assign empty     = (count == '0);

  // Broadcast operation, the new count and the result status.
  always_comb begin
    ctrl.enq    = accept && !is_deq && !full;
    ctrl.deq    = accept && is_deq && !empty;
    ctrl.val    = cmd.value;
    count_next  = count;
    status_next = ST_ENQUEUED;
    if (is_deq) begin
      if (empty) begin
        status_next = ST_UNDERFLOW;
      end else begin
        status_next = ST_DEQUEUED;
        count_next  = count - 1'b1;
      end
    end else begin
      if (full) begin
        status_next = ST_OVERFLOW;
      end else begin
        count_next = count + 1'b1;
      end
    end
  end

  // Row of cells; each sees its left neighbour's take flag and both neighbours' values.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                    occ;
    logic                    lt;
    logic signed [VAL_W-1:0] lv;
    logic signed [VAL_W-1:0] rv;

    assign occ = (CW'(i) < count);
    if (i == 0) begin : g_first
      assign lt = 1'b0;
      assign lv = ctrl.val;
    end else begin : g_inner
      assign lt = take[i-1];
      assign lv = value[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign rv = value[i];
    end else begin : g_mid
      assign rv = value[i+1];
    end

    spq_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .occ         (occ),
      .left_take   (lt),
      .left_value  (lv),
      .right_value (rv),
      .take        (take[i]),
      .value       (value[i])
    );
  end

  // Count and result valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      res_valid <= 1'b0;
    end else begin
      if (accept) begin
        count     <= count_next;
        res_valid <= 1'b1;
      end else if (res.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // Result payload, loaded with each accepted command.
  always_ff @(posedge clk) begin
    if (accept) begin
      res_status  <= status_next;
      res_removed <= (is_deq && !empty) ? value[0] : '0;
      res_occ     <= OCC_W'(count_next);
    end
  end

  assign res.valid         = res_valid;
  assign res.status        = res_status;
  assign res.removed_value = res_removed;
  assign res.occupancy     = res_occ;

  // Checks on the occupancy bookkeeping and the result codes.
  `SPQ_ASSERT(a_count_range, clk, rst, count <= CW'(DEPTH), "occupancy above depth")
  `SPQ_ASSERT(a_overflow, clk, rst,
    accept && !is_deq && full |=> res_valid && res_status == ST_OVERFLOW
      && count == $past(count),
    "overflow not reported or contents changed")
  `SPQ_ASSERT(a_dequeue, clk, rst,
    accept && is_deq && !empty |=> res_status == ST_DEQUEUED
      && count == CW'($past(count) - 1'b1),
    "dequeue did not reduce occupancy")
  `SPQ_ASSERT_ALWAYS(a_reset, clk, rst |=> !res_valid && count == '0,
    "reset did not empty the queue")

endmodule

// File: bench/spq_checker.sv
// Checker for the sorted priority queue: predicts every result word and compares it.
module spq_checker import spq_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic clk,
  input  logic rst,
  spq_cmd_if   cmd,
  spq_res_if   res,
  output int   fail_count,
  output int   pending,
  output int   enqueued_count,
  output int   dequeued_count,
  output int   overflow_count,
  output int   underflow_count,
  output int   full_hits
);
  timeunit 1ns;
  timeprecision 1ps;

  // Only this many mismatch lines are printed; every mismatch is still counted.
  localparam int PRINT_LIMIT = 60;

  typedef struct packed {
    status_t                 status;
    logic signed [VAL_W-1:0] removed_value;
    logic [OCC_W-1:0]        occupancy;
  } result_word_t;

  // Predicted queue contents, smallest value first.
  logic signed [VAL_W-1:0] queue_contents[$];
  // Result words still owed by the block, oldest first.
  result_word_t            owed_results[$];

  task automatic report_mismatch(string field, logic [VAL_W-1:0] got,
                                 logic [VAL_W-1:0] want);
    fail_count++;
    if (fail_count <= PRINT_LIMIT)
      $display("%0t ns: mismatch on %s: got %0h, expected %0h", $time, field, got, want);
  endtask

  // Applies one command to the predicted contents and returns the result word it owes.
  function automatic result_word_t apply_command(cmd_t op, logic signed [VAL_W-1:0] val);
    result_word_t word;
    int           slot;
    word.removed_value = '0;
    if (op == CMD_ENQUEUE) begin
      if (queue_contents.size() >= DEPTH) begin
        word.status = ST_OVERFLOW;
      end else begin
        // The new value goes behind every stored value that is not greater.
        slot = queue_contents.size();
        while (slot > 0 && queue_contents[slot-1] > val) slot--;
        queue_contents.insert(slot, val);
        word.status = ST_ENQUEUED;
      end
    end else if (queue_contents.size() == 0) begin
      word.status = ST_UNDERFLOW;
    end else begin
      word.removed_value = queue_contents.pop_front();
      word.status        = ST_DEQUEUED;
    end
    word.occupancy = OCC_W'(queue_contents.size());
    return word;
  endfunction

  // Result words are compared before the command of the same edge is predicted;
  // a command can never be answered at the edge that accepts it.
  always @(posedge clk) begin
    result_word_t want;
    if (rst) begin
      queue_contents.delete();
      owed_results.delete();
      fail_count      = 0;
      enqueued_count  = 0;
      dequeued_count  = 0;
      overflow_count  = 0;
      underflow_count = 0;
      full_hits       = 0;
    end else begin
      if (res.valid && res.ready) begin
        if (owed_results.size() == 0) begin
          report_mismatch("result word with nothing outstanding",
                          VAL_W'(res.status), '0);
        end else begin
          want = owed_results.pop_front();
          if (res.status !== want.status)
            report_mismatch("status", VAL_W'(res.status), VAL_W'(want.status));
          if (res.removed_value !== want.removed_value)
            report_mismatch("removed_value", res.removed_value, want.removed_value);
          if (res.occupancy !== want.occupancy)
            report_mismatch("occupancy", VAL_W'(res.occupancy), VAL_W'(want.occupancy));
        end
      end
      if (cmd.valid && cmd.ready) begin
        want = apply_command(cmd_t'(cmd.command), cmd.value);
        owed_results.push_back(want);
        case (want.status)
          ST_ENQUEUED: begin
            enqueued_count++;
            if (want.occupancy == OCC_W'(DEPTH)) full_hits++;
          end
          ST_DEQUEUED:  dequeued_count++;
          ST_OVERFLOW:  overflow_count++;
          ST_UNDERFLOW: underflow_count++;
          default: ;
        endcase
      end
    end
    pending <= owed_results.size();
  end

endmodule

// File: bench/sorted_priority_queue_top_tb.sv
// Testbench top for the sorted priority queue: clock, reset, stimulus and verdict.
module sorted_priority_queue_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import spq_pkg::*;

  localparam int RANDOM_ITEMS = 1080;

  // Values that fill the queue in the directed part; extremes, signs and duplicates.
  localparam logic signed [VAL_W-1:0] FILL_VALUES [16] = '{
    32'sh7fff_ffff, 32'sh8000_0000, 32'sh0000_0000, 32'shffff_ffff,
    32'sh0000_0001, 32'sh0000_0005, 32'sh0000_0005, 32'shffff_fffb,
    32'sh8000_0001, 32'sh7fff_fffe, 32'sh0000_0005, 32'sh0000_0000,
    32'shffff_ffff, 32'sh0000_0064, 32'shffff_ff9c, 32'sh5555_aaaa
  };

  logic clk;
  logic rst;

  spq_cmd_if cmd ();
  spq_res_if res ();

  int  fail_count;
  int  pending;
  int  enqueued_count;
  int  dequeued_count;
  int  overflow_count;
  int  underflow_count;
  int  full_hits;
  bit  sender_quiet;
  bit  receiver_quiet;

  sorted_priority_queue_top #(.DEPTH(DEPTH_DEF)) dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd),
    .res (res)
  );

  spq_checker #(.DEPTH(DEPTH_DEF)) queue_monitor (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .res             (res),
    .fail_count      (fail_count),
    .pending         (pending),
    .enqueued_count  (enqueued_count),
    .dequeued_count  (dequeued_count),
    .overflow_count  (overflow_count),
    .underflow_count (underflow_count),
    .full_hits       (full_hits)
  );

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block stops answering.
  initial begin
    #5_000_000;
    $display("Timed out with %0d result words outstanding.", pending);
    $display("*** FAILED ***");
    $finish;
  end

  // Offers one word and holds it until the block takes it. Valid is only lowered
  // when a gap is drawn, so back-to-back words keep it high.
  task automatic send_word(cmd_t op, logic signed [VAL_W-1:0] val);
    int gap;
    gap = sender_quiet ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      cmd.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd.valid   <= 1'b1;
    cmd.command <= op;
    cmd.value   <= val;
    do @(posedge clk); while (!cmd.ready);
  endtask

  // Holds the sender off until every owed result word has come back.
  task automatic wait_drained();
    cmd.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // Mostly full-range values, with a share of small ones for duplicates and of extremes.
  function automatic logic signed [VAL_W-1:0] pick_value();
    case ($urandom_range(0, 3))
      0: return $signed(VAL_W'($urandom_range(0, 8))) - 4;
      1: begin
        case ($urandom_range(0, 3))
          0: return 32'sh8000_0000;
          1: return 32'sh7fff_ffff;
          2: return 32'sh0000_0000;
          default: return 32'shffff_ffff;
        endcase
      end
      default: return $signed(VAL_W'($urandom()));
    endcase
  endfunction

  // Result side: stalls a random number of cycles before each word, with quiet stretches.
  initial begin
    int stall;
    int taken;
    res.ready <= 1'b0;
    taken = 0;
    @(negedge rst);
    forever begin
      if (taken % 50 == 0) receiver_quiet = ($urandom_range(0, 3) == 0);
      stall = receiver_quiet ? 0 : $urandom_range(0, 15);
      if (stall > 0) begin
        res.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res.ready <= 1'b1;
      do @(posedge clk); while (!res.valid);
      taken++;
    end
  end

  // Stimulus: reset, a directed part, then random commands with a drifting mix.
  initial begin
    int   enq_percent;
    cmd_t op;
    rst          <= 1'b1;
    cmd.valid    <= 1'b0;
    cmd.command  <= CMD_ENQUEUE;
    cmd.value    <= '0;
    sender_quiet  = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Dequeue from the empty queue, with every value bit set.
    send_word(CMD_DEQUEUE, 32'shffff_ffff);
    // Fill to the brim, then one enqueue too many.
    foreach (FILL_VALUES[i]) send_word(CMD_ENQUEUE, FILL_VALUES[i]);
    send_word(CMD_ENQUEUE, 32'sh0000_002a);
    // Free some space and show that it is used again at once.
    repeat (3) send_word(CMD_DEQUEUE, 32'sh0000_0000);
    repeat (3) send_word(CMD_ENQUEUE, 32'sh8000_0000);
    send_word(CMD_ENQUEUE, 32'sh0000_0000);
    wait_drained();

    enq_percent = 50;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      // Shift the mix now and then so the queue keeps swinging between empty and full.
      if (n % 40 == 0) begin
        case ($urandom_range(0, 4))
          0: enq_percent = 10;
          1: enq_percent = 30;
          2: enq_percent = 50;
          3: enq_percent = 70;
          default: enq_percent = 90;
        endcase
      end
      if (n % 64 == 0) sender_quiet = ($urandom_range(0, 3) == 0);
      if (n == 360 || n == 720) wait_drained();
      op = ($urandom_range(0, 99) < enq_percent) ? CMD_ENQUEUE : CMD_DEQUEUE;
      send_word(op, pick_value());
    end

    wait_drained();
    repeat (4) @(posedge clk);

    $display("Covered %0d enqueues, %0d dequeues, %0d overflows and %0d underflows;",
             enqueued_count, dequeued_count, overflow_count, underflow_count);
    $display("the queue was filled to capacity %0d times; %0d mismatches.",
             full_hits, fail_count);
    if (fail_count == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
